// ===== sv/swgc_pkg.sv =====
package swgc_pkg;

  localparam int WIN_W   = 16;
  localparam int OFF_W   = 16;
  localparam int TIME_W  = 24;
  localparam int CT_W    = 29;
  localparam int MISS_W  = 22;
  localparam int DEPTH_W = 16;
  localparam int POS_W   = 17;

  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 16'd512;

  // Pedestal jumps repeat every 64 samples.
  localparam int PED_PERIOD = 64;
  localparam int PED_BITS   = $clog2(PED_PERIOD);

  localparam logic [CT_W-1:0] CT_MAX = {1'b0, {(CT_W-1){1'b1}}};
  localparam logic [CT_W-1:0] CT_MIN = {1'b1, {(CT_W-1){1'b0}}};

  localparam logic [MISS_W-1:0] MISS_MAX = {1'b0, {(MISS_W-1){1'b1}}};
  localparam logic [MISS_W-1:0] MISS_MIN = {1'b1, {(MISS_W-1){1'b0}}};

  // One input item with its list positions already worked out.
  typedef struct packed {
    logic [WIN_W-1:0]  window_number;
    logic              has_window;
    logic              last;
    logic [WIN_W-1:0]  sample_rise;
    logic [OFF_W-1:0]  fall_offset;
    logic [TIME_W-1:0] time_req;
    logic [POS_W-1:0]  pos_rise;
    logic [POS_W-1:0]  pos_fall;
    logic [POS_W-1:0]  pos_time;
  } stage_t;

  // Everything the result stage needs from a closed pulse.
  typedef struct packed {
    logic                     c_differ;
    logic [WIN_W-1:0]         rise_win;
    logic [WIN_W-1:0]         fall_win;
    logic signed [MISS_W-1:0] missing;
    logic                     order_ok;
    logic                     repeat_seen;
    logic                     pedestal_jump;
    logic [TIME_W-1:0]        time_req;
  } snap_t;

endpackage

// ===== sv/swgc_if.sv =====
interface swgc_in_if import swgc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [WIN_W-1:0]  window_number;
  logic              has_window;
  logic              last;
  logic [WIN_W-1:0]  sample_rise;
  logic [OFF_W-1:0]  fall_offset;
  logic [TIME_W-1:0] time_req;

  modport source (output valid, window_number, has_window, last, sample_rise,
                  fall_offset, time_req, input ready);
  modport sink   (input valid, window_number, has_window, last, sample_rise,
                  fall_offset, time_req, output ready);
endinterface

interface swgc_out_if import swgc_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic                   window_discontinuity;
  logic                   windows_in_order;
  logic signed [CT_W-1:0] corrected_time;
  logic                   pedestal_jump;
  logic                   repeated_window;

  modport source (output valid, window_discontinuity, windows_in_order, corrected_time,
                  pedestal_jump, repeated_window, input ready);
  modport sink   (input valid, window_discontinuity, windows_in_order, corrected_time,
                  pedestal_jump, repeated_window, output ready);
endinterface

// ===== sv/swgc_pos.sv =====
module swgc_pos import swgc_pkg::*; #(
  parameter int WINDOW_SAMPLES = 64
) (
  input  logic [POS_W-1:0] dividend,
  output logic [POS_W-1:0] quotient
);

  // Division by the window length as a multiplication by a rounded-up
  // reciprocal; the extra shift makes it exact over the whole dividend range.
  localparam int     SH_L  = $clog2(WINDOW_SAMPLES);
  localparam int     SH    = POS_W + SH_L;
  localparam int     MUL_W = POS_W + 1;
  localparam int     PRD_W = POS_W + MUL_W;
  localparam longint MUL   = ((longint'(1) << SH) + WINDOW_SAMPLES - 1) / WINDOW_SAMPLES;
  localparam logic [MUL_W-1:0] RECIP = MUL_W'(MUL);

  logic [PRD_W-1:0] product;

  assign product  = PRD_W'(dividend) * PRD_W'(RECIP);
  assign quotient = POS_W'(product >> SH);

endmodule

// ===== sv/swgc_track.sv =====
module swgc_track import swgc_pkg::*; #(
  parameter int MAX_WINDOWS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  stage_t             item,
  input  logic               fire,
  input  logic [DEPTH_W-1:0] storage_depth,
  output snap_t              snap
);

  localparam int IDX_W = $clog2(MAX_WINDOWS + 1);

  logic [WIN_W-1:0]         prev_r, prev_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [WIN_W-1:0]         rise_win_r, rise_win_nxt;
  logic [WIN_W-1:0]         fall_win_r, fall_win_nxt;
  logic signed [MISS_W-1:0] miss_r, miss_nxt;
  logic                     order_ok_r, order_ok_nxt;
  logic                     repeat_r, repeat_nxt;
  logic                     rise_cap_r, rise_cap_nxt;
  logic                     fall_cap_r, fall_cap_nxt;

  logic                     take;
  logic [POS_W-1:0]         k_ext;
  logic [POS_W-1:0]         size_ext;
  logic [POS_W-1:0]         c0;
  logic [POS_W-1:0]         c1;
  logic signed [WIN_W:0]    gap_raw;
  logic signed [WIN_W:0]    gap;
  logic signed [MISS_W:0]   miss_sum;

  always_comb begin
    take    = item.has_window && (idx_r < IDX_W'(MAX_WINDOWS));
    k_ext   = POS_W'(idx_r);
    gap_raw = $signed({1'b0, item.window_number}) - $signed({1'b0, prev_r});
    // Wrap round the circular storage; a gap can stay negative and is kept so.
    gap     = (gap_raw < 0) ? gap_raw + $signed({1'b0, storage_depth}) : gap_raw;
    miss_sum = (MISS_W+1)'(miss_r) + (MISS_W+1)'(gap) - (MISS_W+1)'(1);

    prev_nxt     = prev_r;
    idx_nxt      = idx_r;
    rise_win_nxt = rise_win_r;
    fall_win_nxt = fall_win_r;
    miss_nxt     = miss_r;
    order_ok_nxt = order_ok_r;
    repeat_nxt   = repeat_r;
    rise_cap_nxt = rise_cap_r;
    fall_cap_nxt = fall_cap_r;

    if (take) begin
      if (idx_r != '0) begin
        if ((k_ext <= item.pos_fall) && (gap != 1)) begin
          order_ok_nxt = 1'b0;
        end
        if (k_ext <= item.pos_time) begin
          if (gap != 1) begin
            if (miss_sum[MISS_W:MISS_W-1] == 2'b01) begin
              miss_nxt = MISS_MAX;
            end else if (miss_sum[MISS_W:MISS_W-1] == 2'b10) begin
              miss_nxt = MISS_MIN;
            end else begin
              miss_nxt = miss_sum[MISS_W-1:0];
            end
          end
          if (gap == 0) begin
            repeat_nxt = 1'b1;
          end
        end
      end
      if (k_ext == item.pos_rise) begin
        rise_win_nxt = item.window_number;
        rise_cap_nxt = 1'b1;
      end
      if (k_ext == item.pos_fall) begin
        fall_win_nxt = item.window_number;
        fall_cap_nxt = 1'b1;
      end
      prev_nxt = item.window_number;
      idx_nxt  = idx_r + IDX_W'(1);
    end

    // Positions past the end of the list fall back to its last window.
    size_ext = POS_W'(idx_nxt);
    c0 = (item.pos_rise < size_ext) ? item.pos_rise : size_ext - POS_W'(1);
    c1 = (item.pos_fall < size_ext) ? item.pos_fall : size_ext - POS_W'(1);

    snap.c_differ    = (idx_nxt != '0) && (c0 != c1);
    snap.rise_win    = rise_cap_nxt ? rise_win_nxt : prev_nxt;
    snap.fall_win    = fall_cap_nxt ? fall_win_nxt : prev_nxt;
    snap.missing     = miss_nxt;
    snap.order_ok    = order_ok_nxt;
    snap.repeat_seen = repeat_nxt;
    snap.time_req    = item.time_req;
    if (item.sample_rise == '0) begin
      snap.pedestal_jump = (item.fall_offset[PED_BITS-1:0] == {PED_BITS{1'b1}});
    end else begin
      snap.pedestal_jump = (item.sample_rise[PED_BITS-1:0] == {PED_BITS{1'b1}}) &&
                           (item.fall_offset[PED_BITS-1:0] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (fire && item.last)) begin
      prev_r     <= '0;
      idx_r      <= '0;
      rise_win_r <= '0;
      fall_win_r <= '0;
      miss_r     <= '0;
      order_ok_r <= 1'b1;
      repeat_r   <= 1'b0;
      rise_cap_r <= 1'b0;
      fall_cap_r <= 1'b0;
    end else if (fire) begin
      prev_r     <= prev_nxt;
      idx_r      <= idx_nxt;
      rise_win_r <= rise_win_nxt;
      fall_win_r <= fall_win_nxt;
      miss_r     <= miss_nxt;
      order_ok_r <= order_ok_nxt;
      repeat_r   <= repeat_nxt;
      rise_cap_r <= rise_cap_nxt;
      fall_cap_r <= fall_cap_nxt;
    end
  end

endmodule

// ===== sv/swgc_result.sv =====
module swgc_result import swgc_pkg::*; #(
  parameter int WINDOW_SAMPLES = 64
) (
  input  snap_t                  snap,
  input  logic [DEPTH_W-1:0]     storage_depth,
  output logic                   discontinuity,
  output logic signed [CT_W-1:0] corrected_time
);

  localparam int WS_W  = $clog2(WINDOW_SAMPLES + 1);
  localparam int PRD_W = MISS_W + WS_W + 1;
  localparam int SUM_W = PRD_W + 9;
  localparam logic signed [WS_W:0] WS_S = (WS_W+1)'(WINDOW_SAMPLES);

  logic signed [WIN_W:0]     gap_raw;
  logic signed [WIN_W:0]     gap;
  logic signed [PRD_W-1:0]   product;
  logic signed [SUM_W-1:0]   sum;
  logic [SUM_W-CT_W:0]       upper;

  always_comb begin
    gap_raw = $signed({1'b0, snap.fall_win}) - $signed({1'b0, snap.rise_win});
    gap     = (gap_raw < 0) ? gap_raw + $signed({1'b0, storage_depth}) : gap_raw;
    discontinuity = snap.c_differ && (gap != 1);

    // Missing windows in samples, then in 1/256 sample units.
    product = PRD_W'(snap.missing) * PRD_W'(WS_S);
    sum     = (SUM_W'(product) <<< 8) + $signed(SUM_W'(snap.time_req));
    upper   = sum[SUM_W-1:CT_W-1];
    if ((upper == '0) || (upper == '1)) begin
      corrected_time = sum[CT_W-1:0];
    end else if (sum[SUM_W-1]) begin
      corrected_time = CT_MIN;
    end else begin
      corrected_time = CT_MAX;
    end
  end

endmodule

// ===== sv/sampling_window_gap_checker.sv =====
// Channel   Direction  Transfer carries
// in_ch     sink       window_number, has_window, last, sample_rise, fall_offset, time_req
// out_ch    source     window_discontinuity, windows_in_order, corrected_time,
//                      pedestal_jump, repeated_window
// cfg_*     write      storage_depth (16 bit)
//
// One input item is taken per cycle while the input is not stopped. After the transfer of the last
// item of a pulse, the item register, the tracker snapshot, then the result register carry it.
// Reset is synchronous and clears the pipeline and the per-pulse state; storage_depth
// returns to 512. Items that close no pulse never wait for the output. While a result waits,
// input stops only when a closing item reaches the tracker with the snapshot stage full.
module sampling_window_gap_checker import swgc_pkg::*; #(
  parameter int WINDOW_SAMPLES = 64,
  parameter int MAX_WINDOWS    = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  swgc_in_if.sink            in_ch,
  swgc_out_if.source         out_ch,
  input  logic               cfg_wr_en,
  input  logic [DEPTH_W-1:0] cfg_wr_data
);

  logic [DEPTH_W-1:0]     depth_r;
  logic                   s1_valid_r;
  stage_t                 s1_r;
  stage_t                 s1_nxt;
  logic                   s2_valid_r;
  snap_t                  s2_r;
  snap_t                  snap;
  logic                   out_valid_r;
  logic                   out_disc_r;
  logic                   out_order_r;
  logic signed [CT_W-1:0] out_time_r;
  logic                   out_ped_r;
  logic                   out_rep_r;
  logic                   disc;
  logic signed [CT_W-1:0] ctime;
  logic [POS_W-1:0]       pos_rise;
  logic [POS_W-1:0]       pos_fall;
  logic [POS_W-1:0]       pos_time;
  logic [POS_W-1:0]       fall_plus;

  logic out_load;
  logic s2_ready;
  logic fire2;
  logic s1_ready;

  assign out_load = s2_valid_r && (!out_valid_r || out_ch.ready);
  assign s2_ready = !s2_valid_r || out_load;
  // Items that do not close a pulse leave the tracker without needing the result stage.
  assign fire2    = s1_valid_r && (!s1_r.last || s2_ready);
  assign s1_ready = !s1_valid_r || fire2;
  assign in_ch.ready = s1_ready;

  assign fall_plus = POS_W'(in_ch.sample_rise) + POS_W'(in_ch.fall_offset) + POS_W'(1);

  swgc_pos #(.WINDOW_SAMPLES(WINDOW_SAMPLES)) u_pos_rise (
    .dividend (POS_W'(in_ch.sample_rise)),
    .quotient (pos_rise)
  );

  swgc_pos #(.WINDOW_SAMPLES(WINDOW_SAMPLES)) u_pos_fall (
    .dividend (fall_plus),
    .quotient (pos_fall)
  );

  swgc_pos #(.WINDOW_SAMPLES(WINDOW_SAMPLES)) u_pos_time (
    .dividend (POS_W'(in_ch.time_req[TIME_W-1:8])),
    .quotient (pos_time)
  );

  always_comb begin
    s1_nxt.window_number = in_ch.window_number;
    s1_nxt.has_window    = in_ch.has_window;
    s1_nxt.last          = in_ch.last;
    s1_nxt.sample_rise   = in_ch.sample_rise;
    s1_nxt.fall_offset   = in_ch.fall_offset;
    s1_nxt.time_req      = in_ch.time_req;
    s1_nxt.pos_rise      = pos_rise;
    s1_nxt.pos_fall      = pos_fall;
    s1_nxt.pos_time      = pos_time;
  end

  swgc_track #(.MAX_WINDOWS(MAX_WINDOWS)) u_track (
    .clk           (clk),
    .rst_n         (rst_n),
    .item          (s1_r),
    .fire          (fire2),
    .storage_depth (depth_r),
    .snap          (snap)
  );

  swgc_result #(.WINDOW_SAMPLES(WINDOW_SAMPLES)) u_result (
    .snap           (s2_r),
    .storage_depth  (depth_r),
    .discontinuity  (disc),
    .corrected_time (ctime)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= DEPTH_RESET;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        depth_r <= cfg_wr_data;
      end
      if (s1_ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s2_ready) begin
        s2_valid_r <= fire2 && s1_r.last;
      end
      if (!out_valid_r || out_ch.ready) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_ch.valid) begin
      s1_r <= s1_nxt;
    end
    if (fire2 && s1_r.last) begin
      s2_r <= snap;
    end
    if (out_load) begin
      out_disc_r  <= disc;
      out_order_r <= s2_r.order_ok;
      out_time_r  <= ctime;
      out_ped_r   <= s2_r.pedestal_jump;
      out_rep_r   <= s2_r.repeat_seen;
    end
  end

  assign out_ch.valid                = out_valid_r;
  assign out_ch.window_discontinuity = out_disc_r;
  assign out_ch.windows_in_order     = out_order_r;
  assign out_ch.corrected_time       = out_time_r;
  assign out_ch.pedestal_jump        = out_ped_r;
  assign out_ch.repeated_window      = out_rep_r;

endmodule

// ===== test/tb_sampling_window_gap_checker.sv =====
module tb_sampling_window_gap_checker;
  timeunit 1ns;
  timeprecision 1ps;
  import swgc_pkg::*;

  localparam int SAMPLES_PER_WIN = 64;
  localparam int LIST_LIMIT      = 256;
  localparam int SKIPPED_HI      = 2097151;
  localparam int SKIPPED_LO      = -2097152;
  localparam longint CT_HI       = 268435455;
  localparam longint CT_LO       = -268435456;
  localparam int TARGET_ITEMS    = 950;
  localparam int PHASE_ITEMS     = 80;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 10;
  localparam int CYCLE_LIMIT     = 300000;
  localparam int PRINT_LIMIT     = 100;

  typedef struct {
    logic [WIN_W-1:0]  window_number;
    logic              has_window;
    logic              last;
    logic [WIN_W-1:0]  sample_rise;
    logic [OFF_W-1:0]  fall_offset;
    logic [TIME_W-1:0] time_req;
  } win_item_t;

  typedef struct {
    logic            window_discontinuity;
    logic            windows_in_order;
    logic [CT_W-1:0] corrected_time;
    logic            pedestal_jump;
    logic            repeated_window;
  } pulse_result_t;

  // Tracks the per-pulse window bookkeeping and queues the result each closed pulse owes.
  class window_gap_tracker;
    bit [DEPTH_W-1:0] depth;
    bit [WIN_W-1:0]   last_win;
    bit [WIN_W-1:0]   rise_win;
    bit [WIN_W-1:0]   fall_win;
    int               win_count;
    int               skipped;
    bit               in_order;
    bit               dup_seen;
    bit               rise_seen;
    bit               fall_seen;
    pulse_result_t    pending_results[$];
    int               errors;

    function new();
      depth  = DEPTH_RESET;
      errors = 0;
      clear_pulse();
    endfunction

    function void clear_pulse();
      last_win  = '0;
      rise_win  = '0;
      fall_win  = '0;
      win_count = 0;
      skipped   = 0;
      in_order  = 1'b1;
      dup_seen  = 1'b0;
      rise_seen = 1'b0;
      fall_seen = 1'b0;
    endfunction

    task report_mismatch(string msg);
      if (errors < PRINT_LIMIT)
        $display("[%0t] ERROR: %s", $time, msg);
      errors++;
    endtask

    // Gap from one window to the next, wrapped once by the storage depth.
    function int wrapped_gap(bit [WIN_W-1:0] from_win, bit [WIN_W-1:0] to_win);
      int a;
      int b;
      int d;
      a = from_win;
      b = to_win;
      d = depth;
      if (b - a < 0)
        return b - a + d;
      return b - a;
    endfunction

    function void accept_item(win_item_t it);
      int            rise;
      int            span;
      int            pos_rise;
      int            pos_fall;
      int            count_end;
      int            gap;
      int            sum;
      int            c0;
      int            c1;
      longint        ct;
      pulse_result_t r;
      rise      = it.sample_rise;
      span      = it.fall_offset;
      pos_rise  = rise / SAMPLES_PER_WIN;
      pos_fall  = (rise + span + 1) / SAMPLES_PER_WIN;
      count_end = it.time_req[TIME_W-1:8];
      count_end = count_end / SAMPLES_PER_WIN + 1;

      if (it.has_window && win_count < LIST_LIMIT) begin
        if (win_count >= 1) begin
          gap = wrapped_gap(last_win, it.window_number);
          if (win_count <= pos_fall && gap != 1)
            in_order = 1'b0;
          if (win_count < count_end) begin
            if (gap != 1) begin
              sum = skipped + gap - 1;
              if (sum > SKIPPED_HI) sum = SKIPPED_HI;
              if (sum < SKIPPED_LO) sum = SKIPPED_LO;
              skipped = sum;
            end
            if (gap == 0)
              dup_seen = 1'b1;
          end
        end
        if (win_count == pos_rise) begin
          rise_win  = it.window_number;
          rise_seen = 1'b1;
        end
        if (win_count == pos_fall) begin
          fall_win  = it.window_number;
          fall_seen = 1'b1;
        end
        last_win = it.window_number;
        win_count++;
      end

      if (!it.last)
        return;

      r.window_discontinuity = 1'b0;
      ct = it.time_req;
      if (win_count > 0) begin
        // Positions beyond the list fall back to its last window.
        c0 = (pos_rise < win_count) ? pos_rise : win_count - 1;
        c1 = (pos_fall < win_count) ? pos_fall : win_count - 1;
        if (c0 != c1)
          r.window_discontinuity = wrapped_gap(rise_seen ? rise_win : last_win,
                                               fall_seen ? fall_win : last_win) != 1;
        ct += longint'(skipped) * SAMPLES_PER_WIN * 256;
        if (ct > CT_HI) ct = CT_HI;
        if (ct < CT_LO) ct = CT_LO;
      end
      r.windows_in_order = in_order;
      r.corrected_time   = ct[CT_W-1:0];
      if (rise == 0)
        r.pedestal_jump = ((span + 1) % PED_PERIOD) == 0;
      else if (((rise + 1) % PED_PERIOD) == 0)
        r.pedestal_jump = (span % PED_PERIOD) == 0;
      else
        r.pedestal_jump = 1'b0;
      r.repeated_window = dup_seen;
      pending_results.push_back(r);
      clear_pulse();
    endfunction

    task check_result(pulse_result_t got);
      pulse_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with no closed pulse waiting");
        return;
      end
      want = pending_results.pop_front();
      if (got.window_discontinuity !== want.window_discontinuity)
        report_mismatch($sformatf("window_discontinuity got %b want %b",
                                  got.window_discontinuity, want.window_discontinuity));
      if (got.windows_in_order !== want.windows_in_order)
        report_mismatch($sformatf("windows_in_order got %b want %b",
                                  got.windows_in_order, want.windows_in_order));
      if (got.corrected_time !== want.corrected_time)
        report_mismatch($sformatf("corrected_time got %0d want %0d",
                                  $signed(got.corrected_time), $signed(want.corrected_time)));
      if (got.pedestal_jump !== want.pedestal_jump)
        report_mismatch($sformatf("pedestal_jump got %b want %b",
                                  got.pedestal_jump, want.pedestal_jump));
      if (got.repeated_window !== want.repeated_window)
        report_mismatch($sformatf("repeated_window got %b want %b",
                                  got.repeated_window, want.repeated_window));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [DEPTH_W-1:0] cfg_wr_data;

  swgc_in_if  in_if ();
  swgc_out_if out_if ();

  sampling_window_gap_checker u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #1 clk = ~clk;

  window_gap_tracker tracker;
  win_item_t         stim_q[$];
  bit                gaps_on;
  int                burst_left;
  int                items_sent;
  logic              hold_req;
  int                cycles;

  function automatic void add_item(int w, bit has, bit fin, int rise, int span, int tq);
    win_item_t it;
    it.window_number = w[WIN_W-1:0];
    it.has_window    = has;
    it.last          = fin;
    it.sample_rise   = rise[WIN_W-1:0];
    it.fall_offset   = span[OFF_W-1:0];
    it.time_req      = tq[TIME_W-1:0];
    stim_q.push_back(it);
  endfunction

  // A pulse whose windows mostly follow on one from the next; flaw_odds sets how
  // often a window skips, repeats or jumps instead.
  function automatic void add_pulse(int len, int flaw_odds);
    int rise;
    int span;
    int tq;
    int wnum;
    int d;
    bit closer;
    d = tracker.depth;
    case ($urandom_range(0, 5))
      0:       rise = 0;
      1:       rise = SAMPLES_PER_WIN * $urandom_range(1, len) - 1;
      default: rise = $urandom_range(0, len * SAMPLES_PER_WIN - 1);
    endcase
    case ($urandom_range(0, 5))
      0:       span = SAMPLES_PER_WIN * $urandom_range(0, len);
      1:       span = SAMPLES_PER_WIN * $urandom_range(1, len) - 1;
      default: span = $urandom_range(0, len * SAMPLES_PER_WIN);
    endcase
    if ($urandom_range(0, 7) == 0)
      tq = $urandom_range(0, 24'hFFFFFF);
    else
      tq = $urandom_range(0, len * SAMPLES_PER_WIN * 256 - 1);
    wnum   = (d > 0) ? $urandom_range(0, d - 1) : $urandom_range(0, 65535);
    closer = ($urandom_range(0, 14) == 0);
    for (int i = 0; i < len; i++) begin
      if (i > 0) begin
        if ($urandom_range(1, flaw_odds) == 1) begin
          case ($urandom_range(0, 2))
            0: wnum = wnum + $urandom_range(2, 5);
            1: wnum = wnum;
            default: wnum = $urandom_range(0, 65535);
          endcase
        end else begin
          wnum = (d > 1) ? (wnum + 1) % d : wnum + 1;
        end
        wnum = wnum & 16'hFFFF;
      end
      if ($urandom_range(0, 19) == 0)
        add_item($urandom, 1'b0, 1'b0, rise, span, tq);
      if ($urandom_range(0, 29) == 0) begin
        rise = $urandom_range(0, 65535);
        span = $urandom_range(0, 65535);
        tq   = $urandom_range(0, 24'hFFFFFF);
      end
      add_item(wnum, 1'b1, (i == len - 1) && !closer, rise, span, tq);
    end
    if (closer)
      add_item($urandom, 1'b0, 1'b1, rise, span, tq);
  endfunction

  // Large window jumps that drive the missing count and the time into saturation.
  function automatic void add_jump_pulse();
    int len;
    int wnum;
    int tq;
    int rise;
    int span;
    if ($urandom_range(0, 1) == 1) begin
      len  = $urandom_range(34, 45);
      tq   = $urandom_range(24'h100000, 24'hFFFFFF);
      rise = $urandom_range(0, 65535);
      span = $urandom_range(0, 65535);
      wnum = $urandom_range(0, 65535);
      for (int i = 0; i < len; i++) begin
        if (i > 0)
          wnum = (wnum - $urandom_range(1, 3)) & 16'hFFFF;
        add_item(wnum, 1'b1, i == len - 1, rise, span, tq);
      end
    end else begin
      tq = $urandom_range(16384, 24'hFFFFFF);
      add_item($urandom_range(60000, 65535), 1'b1, 1'b0, 0, 64, tq);
      add_item($urandom_range(0, 100), 1'b1, 1'b1, 0, 64, tq);
    end
  endfunction

  function automatic void build_random(int n_items);
    int start;
    start = stim_q.size();
    while (stim_q.size() - start < n_items) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          repeat ($urandom_range(1, 4))
            add_item($urandom, $urandom_range(0, 1), $urandom_range(0, 3) == 0,
                     $urandom, $urandom, $urandom);
        end
        2:       add_pulse($urandom_range(1, 8), 3);
        3:       add_jump_pulse();
        4:       add_item($urandom, 1'b0, 1'b1, $urandom, $urandom, $urandom);
        default: add_pulse(($urandom_range(0, 7) == 0) ? $urandom_range(9, 24)
                                                        : $urandom_range(1, 8), 40);
      endcase
    end
  endfunction

  function automatic void build_directed();
    add_item(0, 1'b0, 1'b1, 0, 0, 0);
    add_item(65535, 1'b1, 1'b1, 0, 63, 24'hABCDEF);
    // Rise one sample short of a 64-sample boundary with the fall a whole period later.
    add_item(10, 1'b1, 1'b0, 63, 64, 40000);
    add_item(11, 1'b1, 1'b0, 63, 64, 40000);
    add_item(12, 1'b1, 1'b1, 63, 64, 40000);
    add_item(5, 1'b1, 1'b0, 0, 70, 24'hFFFFFF);
    add_item(5, 1'b1, 1'b0, 0, 70, 24'hFFFFFF);
    add_item(6, 1'b1, 1'b1, 0, 70, 24'hFFFFFF);
    // Wraps through the end of the 512-window storage.
    add_item(510, 1'b1, 1'b0, 100, 120, 24'h0FFFFF);
    add_item(511, 1'b1, 1'b0, 100, 120, 24'h0FFFFF);
    add_item(0, 1'b1, 1'b0, 100, 120, 24'h0FFFFF);
    add_item(1, 1'b1, 1'b1, 100, 120, 24'h0FFFFF);
    add_item(7, 1'b1, 1'b0, 65535, 65535, 1000);
    add_item(9, 1'b1, 1'b1, 65535, 65535, 1000);
    add_item(60000, 1'b1, 1'b0, 0, 64, 24'hFFFFFF);
    add_item(100, 1'b1, 1'b1, 0, 64, 24'hFFFFFF);
    add_item(3, 1'b1, 1'b0, 0, 200, 60000);
    add_item(65535, 1'b0, 1'b0, 0, 200, 60000);
    add_item(4, 1'b1, 1'b0, 0, 200, 60000);
    add_item(0, 1'b0, 1'b1, 0, 200, 60000);
    add_item(20, 1'b1, 1'b0, 0, 64, 20000);
    add_item(22, 1'b1, 1'b1, 0, 64, 20000);
    // Pulse fields change between items; the last item's values count.
    add_item(30, 1'b1, 1'b0, 65535, 65535, 24'hFFFFFF);
    add_item(31, 1'b1, 1'b1, 64, 0, 5000);
  endfunction

  task automatic send_item(win_item_t it);
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 20);
      end
      burst_left--;
    end
    in_if.valid         <= 1'b1;
    in_if.window_number <= it.window_number;
    in_if.has_window    <= it.has_window;
    in_if.last          <= it.last;
    in_if.sample_rise   <= it.sample_rise;
    in_if.fall_offset   <= it.fall_offset;
    in_if.time_req      <= it.time_req;
    @(posedge clk);
    while (!in_if.ready)
      @(posedge clk);
    tracker.accept_item(it);
  endtask

  task automatic drive_queue();
    foreach (stim_q[i])
      send_item(stim_q[i]);
    in_if.valid <= 1'b0;
    items_sent += stim_q.size();
    stim_q.delete();
  endtask

  task automatic settle();
    while (tracker.pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_depth(bit [DEPTH_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    tracker.depth = value;
  endtask

  // Result side: checks every transfer and stalls on a pattern of its own.
  initial begin
    int            mode;
    int            mode_left;
    int            stall_left;
    int            hold_left;
    bit            hold_used;
    pulse_result_t got;
    mode       = 0;
    mode_left  = 0;
    stall_left = 0;
    hold_left  = 0;
    hold_used  = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        got.window_discontinuity = out_if.window_discontinuity;
        got.windows_in_order     = out_if.windows_in_order;
        got.corrected_time       = out_if.corrected_time;
        got.pedestal_jump        = out_if.pedestal_jump;
        got.repeated_window      = out_if.repeated_window;
        tracker.check_result(got);
      end
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= $urandom_range(0, 1);
          2: begin
            if (stall_left > 0) begin
              stall_left--;
              out_if.ready <= 1'b0;
            end else begin
              out_if.ready <= 1'b1;
              if ($urandom_range(0, 3) == 0)
                stall_left = $urandom_range(1, 8);
            end
          end
          default: out_if.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("sampling_window_gap_checker: mismatch");
    $finish;
  end

  initial begin
    int               phase;
    bit [DEPTH_W-1:0] depth_val;
    tracker = new();
    rst_n               <= 1'b0;
    cfg_wr_en           <= 1'b0;
    cfg_wr_data         <= '0;
    hold_req            <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.window_number <= '0;
    in_if.has_window    <= 1'b0;
    in_if.last          <= 1'b0;
    in_if.sample_rise   <= '0;
    in_if.fall_offset   <= '0;
    in_if.time_req      <= '0;
    gaps_on    = 1'b1;
    burst_left = 0;
    items_sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    build_directed();
    drive_queue();
    settle();

    phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      case (phase)
        0:       depth_val = 1;
        1:       depth_val = 16'hFFFF;
        2:       depth_val = 0;
        3:       depth_val = 512;
        4:       depth_val = 2;
        5:       depth_val = 64;
        6:       depth_val = 16'hFFFF;
        7:       depth_val = 1000;
        default: depth_val = $urandom_range(1, 65535);
      endcase
      write_depth(depth_val);
      gaps_on = (phase % 3) != 2;
      case (phase)
        1: begin
          repeat (4) add_jump_pulse();
          build_random(PHASE_ITEMS / 2);
        end
        3: begin
          // A list longer than the block keeps; the excess windows are dropped.
          add_pulse($urandom_range(LIST_LIMIT + 1, LIST_LIMIT + 14), 40);
          build_random(PHASE_ITEMS / 2);
        end
        5: begin
          // Every transfer closes a pulse while the receiver holds off, so the
          // block fills and has to stall its input.
          gaps_on = 1'b0;
          hold_req <= 1'b1;
          repeat (PHASE_ITEMS)
            add_item($urandom, 1'b1, 1'b1, $urandom, $urandom, $urandom);
        end
        default: build_random(PHASE_ITEMS);
      endcase
      add_item($urandom, 1'b0, 1'b1, $urandom, $urandom, $urandom);
      drive_queue();
      settle();
      phase++;
    end

    if (tracker.pending_results.size() != 0)
      tracker.report_mismatch($sformatf("%0d results never arrived",
                                        tracker.pending_results.size()));
    if (tracker.errors == 0)
      $display("sampling_window_gap_checker: match");
    else
      $display("sampling_window_gap_checker: mismatch");
    $finish;
  end

endmodule
